/* rtl/bmo_pkg.sv */
// ----------------------------------------------------------------------------
// Bicycle model odometry package
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package bmo_pkg;

   localparam int ANGLE_BITS_DEF    = 24;
   localparam int POSITION_BITS_DEF = 40;
   localparam int CORDIC_STEPS_DEF  = 20;

   localparam int TS_W    = 32;
   localparam int DIST_W  = 24;
   localparam int STEER_W = 16;
   localparam int RATE_W  = 24;
   localparam int IWB_W   = 16;
   localparam int CORD_W  = 34;
   localparam int DIVN_W  = 56;
   localparam int DIVD_W  = 40;

   localparam logic [IWB_W-1:0]         IWB_RESET     = 16'd21557;
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN   = 34'sd652032874;
   localparam logic [31:0]              RAD_TO_TURN34 = 32'd2734261102;
   localparam logic [21:0]              RAD_TO_TURN24 = 22'd2670177;
   localparam logic [9:0]               MS_PER_S      = 10'd1000;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/bmo_if.sv */
// ----------------------------------------------------------------------------
// Bicycle model odometry channels
// Sample and pose channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmo_req_if
   import bmo_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [TS_W-1:0]           timestamp_ms;
   logic signed [DIST_W-1:0]  distance;
   logic signed [STEER_W-1:0] steer;

   modport source (output valid, timestamp_ms, distance, steer, input ready);
   modport sink   (input valid, timestamp_ms, distance, steer, output ready);
endinterface

interface bmo_rsp_if
   import bmo_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic signed [POSITION_BITS-1:0] pos_x;
   logic signed [POSITION_BITS-1:0] pos_y;
   logic [ANGLE_BITS-1:0]           heading;
   logic signed [RATE_W-1:0]        rate_x;
   logic signed [RATE_W-1:0]        rate_y;
   logic signed [RATE_W-1:0]        turn_rate;
   logic                            zero_step;

   modport source (output valid, pos_x, pos_y, heading, rate_x, rate_y, turn_rate,
                   zero_step, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, rate_x, rate_y, turn_rate,
                   zero_step, output ready);
endinterface

/* rtl/bmo_cordic.sv */
// ----------------------------------------------------------------------------
// Bicycle model odometry CORDIC
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module bmo_cordic
   import bmo_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              angle,
   output logic                     done,
   output logic signed [CORD_W-1:0] cos_out,
   output logic signed [CORD_W-1:0] sin_out
);

   localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     flip_ff, flip_in;
   logic [SW-1:0]            step_ff, step_in;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CORD_W-1:0] xs, ys, at;
   logic [31:0]              a2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      at      = CORD_W'($signed({1'b0, atan_turn(5'(step_ff))}));
      a2      = angle;
      if (start) begin
         flip_in = a2[31] ^ a2[30];
         if (flip_in) begin
            a2 = angle + 32'h8000_0000;
         end
         busy_in = 1'b1;
         step_in = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = CORD_W'($signed(a2));
      end else if (busy_ff) begin
         if (!z_ff[CORD_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         if (32'(step_ff) == 32'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

/* rtl/bmo_divider.sv */
// ----------------------------------------------------------------------------
// Bicycle model odometry divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmo_divider
   import bmo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done,
   output logic [DIVN_W-1:0] quotient
);

   localparam int CW = $clog2(DIVN_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIVN_W-1:0] num_ff, num_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [DIVD_W:0]   rem_sh, diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, num_ff[DIVN_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVD_W]) begin
            rem_in = diff[DIVD_W-1:0];
            num_in = {num_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIVD_W-1:0];
            num_in = {num_ff[DIVN_W-2:0], 1'b0};
         end
         if (cnt_ff == CW'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

/* rtl/bicycle_model_odometry.sv */
// A sample beat runs the shared CORDIC on the heading, then on the steering angle, then
// the bit-serial divider (tan quotient and three rates), before pose valid;
// a zero time step skips the rate divisions, a zero cosine skips the tan division.
// No new sample is taken until the pose beat is taken (result stalls); req ready only while
// idle. A first sample only stores its timestamp. Reset (synchronous): pose, heading and
// previous time cleared, awaiting first sample, inverse wheelbase back to 21557.
// ----------------------------------------------------------------------------
// Bicycle model odometry
// Dead reckoning with the kinematic bicycle model over a shared CORDIC and divider.
// ----------------------------------------------------------------------------
module bicycle_model_odometry
   import bmo_pkg::*;
#(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   bmo_req_if.sink          req_bus,
   bmo_rsp_if.source        rsp_bus,
   input  logic             csr_we,
   input  logic [IWB_W-1:0] csr_wdata
);

   localparam int PB    = POSITION_BITS;
   localparam int AB    = ANGLE_BITS;
   localparam int PX_W  = DIST_W + CORD_W;
   localparam int PXI_W = PX_W - 29;
   localparam int SUM_W = ((PB > PXI_W) ? PB : PXI_W) + 1;
   localparam int M_W   = 30;
   localparam int TN_W  = 32;
   localparam int D_W   = 47;
   localparam int HP_W  = D_W + 23;
   localparam int RS    = 48 - AB;
   localparam logic signed [SUM_W-1:0] POS_HI = {{(SUM_W-PB+1){1'b0}}, {(PB-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_CH   = 9'b000000010,
      S_CS   = 9'b000000100,
      S_TDIV = 9'b000001000,
      S_MUL1 = 9'b000010000,
      S_MUL2 = 9'b000100000,
      S_HEAD = 9'b001000000,
      S_RDIV = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   state_type                state_ff, state_in;
   logic                     first_ff, first_in;
   logic [TS_W-1:0]          prev_ff, prev_in;
   logic [IWB_W-1:0]         ivw_ff, ivw_in;
   logic [AB-1:0]            head_ff, head_in;
   logic signed [PB-1:0]     posx_ff, posx_in, posy_ff, posy_in;
   logic signed [DIST_W-1:0] dist_ff, dist_in;
   logic [TS_W-1:0]          dt_ff, dt_in;
   logic [31:0]              sturn_ff, sturn_in;
   logic signed [PX_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [CORD_W-1:0] sc_ff, sc_in, ss_ff, ss_in;
   logic signed [TN_W-1:0]   tan_ff, tan_in;
   logic signed [M_W-1:0]    m_ff, m_in;
   logic signed [D_W-1:0]    dth_ff, dth_in;
   logic signed [RATE_W-1:0] rx_ff, rx_in, ry_ff, ry_in, rt_ff, rt_in;
   logic                     zero_ff, zero_in;
   logic [1:0]               ridx_ff, ridx_in;
   logic                     dgo_ff, dgo_in;

   logic                     cord_go, cord_done;
   logic [31:0]              cord_ang;
   logic signed [CORD_W-1:0] cord_cos, cord_sin;
   logic                     div_done;
   logic [DIVN_W-1:0]        div_num, div_q;
   logic [DIVD_W-1:0]        div_den;

   logic                     accept;
   logic signed [48:0]       sprod;
   logic signed [PX_W:0]     rnd30x, rnd30y;
   logic signed [SUM_W-1:0]  sumx, sumy;
   logic signed [40:0]       mprod;
   logic signed [41:0]       mrnd;
   logic signed [61:0]       dprod;
   logic signed [62:0]       drnd;
   logic signed [HP_W-1:0]   hprod, hrnd;
   logic signed [PX_W:0]     rnd22;
   logic signed [63:0]       rnum;
   logic                     div_neg;
   logic [DIVN_W-1:0]        rmag;
   logic signed [RATE_W-1:0] rsat;
   logic                     tneg;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign cord_ang      = (state_ff == S_IDLE) ? 32'({head_ff, 32'd0} >> AB) : sturn_ff;
   assign cord_go       = (accept && !first_ff) || (state_ff == S_CH && cord_done);

   bmo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_go),
      .angle   (cord_ang),
      .done    (cord_done),
      .cos_out (cord_cos),
      .sin_out (cord_sin)
   );

   always_comb begin
      rnd22 = (PX_W+1)'(px_ff);
      case (ridx_ff)
         2'd0:    rnd22 = ((PX_W+1)'(px_ff) + (PX_W+1)'(64'sd1 <<< 21)) >>> 22;
         2'd1:    rnd22 = ((PX_W+1)'(py_ff) + (PX_W+1)'(64'sd1 <<< 21)) >>> 22;
         default: rnd22 = '0;
      endcase
      if (ridx_ff == 2'd2) begin
         rnum = 64'(dth_ff) * 64'sd1000;
      end else begin
         rnum = 64'(rnd22) * $signed({54'd0, MS_PER_S});
      end
      if (state_ff == S_TDIV) begin
         div_neg = ss_ff[CORD_W-1] ^ sc_ff[CORD_W-1];
         div_num = DIVN_W'(ss_ff[CORD_W-1] ? -64'(ss_ff) : 64'(ss_ff)) << 24;
         div_den = DIVD_W'(sc_ff[CORD_W-1] ? -(CORD_W+1)'(sc_ff) : (CORD_W+1)'(sc_ff));
      end else begin
         div_neg = rnum[63];
         div_num = DIVN_W'(rnum[63] ? -rnum : rnum);
         div_den = {dt_ff, 8'd0};
      end
   end

   bmo_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (dgo_ff),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      ivw_in   = csr_we ? csr_wdata : ivw_ff;
      head_in  = head_ff;
      posx_in  = posx_ff;
      posy_in  = posy_ff;
      dist_in  = dist_ff;
      dt_in    = dt_ff;
      sturn_in = sturn_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      sc_in    = sc_ff;
      ss_in    = ss_ff;
      tan_in   = tan_ff;
      m_in     = m_ff;
      dth_in   = dth_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rt_in    = rt_ff;
      zero_in  = zero_ff;
      ridx_in  = ridx_ff;
      dgo_in   = 1'b0;

      sprod  = 49'(req_bus.steer) * $signed({17'd0, RAD_TO_TURN34});
      rnd30x = ((PX_W+1)'(px_ff) + (PX_W+1)'(64'sd1 <<< 29)) >>> 30;
      rnd30y = ((PX_W+1)'(py_ff) + (PX_W+1)'(64'sd1 <<< 29)) >>> 30;
      sumx   = SUM_W'(posx_ff) + SUM_W'($signed(rnd30x[PXI_W-1:0]));
      sumy   = SUM_W'(posy_ff) + SUM_W'($signed(rnd30y[PXI_W-1:0]));
      mprod  = 41'(dist_ff) * $signed({25'd0, ivw_ff});
      mrnd   = (42'(mprod) + 42'sd2048) >>> 12;
      dprod  = 62'(m_ff) * 62'(tan_ff);
      drnd   = (63'(dprod) + 63'sd32768) >>> 16;
      hprod  = HP_W'(dth_ff) * $signed({(HP_W-22)'(0), RAD_TO_TURN24});
      hrnd   = (hprod + (HP_W'(1) <<< (RS - 1))) >>> RS;

      tneg = ss_ff[CORD_W-1] ^ sc_ff[CORD_W-1];
      if (div_neg) begin
         rsat = (div_q > DIVN_W'(64'd8388608)) ? -24'sd8388608 : -RATE_W'(div_q);
      end else begin
         rsat = (div_q > DIVN_W'(64'd8388607)) ? 24'sd8388607 : RATE_W'(div_q);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_in = req_bus.timestamp_ms;
               if (first_ff) begin
                  first_in = 1'b0;
               end else begin
                  dt_in    = req_bus.timestamp_ms - prev_ff;
                  dist_in  = req_bus.distance;
                  sturn_in = sprod[47:16];
                  state_in = S_CH;
               end
            end
         end
         S_CH: begin
            if (cord_done) begin
               px_in    = PX_W'(dist_ff) * PX_W'(cord_cos);
               py_in    = PX_W'(dist_ff) * PX_W'(cord_sin);
               state_in = S_CS;
            end
         end
         S_CS: begin
            if (cord_done) begin
               sc_in = cord_cos;
               ss_in = cord_sin;
               if (cord_cos == '0) begin
                  tan_in   = cord_sin[CORD_W-1] ? -32'sd1073741824 : 32'sd1073741824;
                  state_in = S_MUL1;
               end else begin
                  dgo_in   = 1'b1;
                  state_in = S_TDIV;
               end
            end
         end
         S_TDIV: begin
            if (div_done) begin
               if (div_q > DIVN_W'(64'd1073741824)) begin
                  tan_in = tneg ? -32'sd1073741824 : 32'sd1073741824;
               end else begin
                  tan_in = tneg ? -TN_W'(div_q) : TN_W'(div_q);
               end
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            m_in = M_W'(mrnd);
            if (sumx > POS_HI) begin
               posx_in = PB'(POS_HI);
            end else if (sumx < POS_LO) begin
               posx_in = PB'(POS_LO);
            end else begin
               posx_in = PB'(sumx);
            end
            if (sumy > POS_HI) begin
               posy_in = PB'(POS_HI);
            end else if (sumy < POS_LO) begin
               posy_in = PB'(POS_LO);
            end else begin
               posy_in = PB'(sumy);
            end
            state_in = S_MUL2;
         end
         S_MUL2: begin
            dth_in   = D_W'(drnd);
            state_in = S_HEAD;
         end
         S_HEAD: begin
            head_in = head_ff + AB'(hrnd);
            ridx_in = 2'd0;
            if (dt_ff == '0) begin
               zero_in  = 1'b1;
               rx_in    = '0;
               ry_in    = '0;
               rt_in    = '0;
               state_in = S_OUT;
            end else begin
               zero_in  = 1'b0;
               dgo_in   = 1'b1;
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_done) begin
               case (ridx_ff)
                  2'd0:    rx_in = rsat;
                  2'd1:    ry_in = rsat;
                  default: rt_in = rsat;
               endcase
               if (ridx_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  ridx_in = ridx_ff + 2'd1;
                  dgo_in  = 1'b1;
               end
            end
         end
         S_OUT: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b1;
         prev_ff  <= '0;
         ivw_ff   <= IWB_RESET;
         head_ff  <= '0;
         posx_ff  <= '0;
         posy_ff  <= '0;
         ridx_ff  <= '0;
         dgo_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         prev_ff  <= prev_in;
         ivw_ff   <= ivw_in;
         head_ff  <= head_in;
         posx_ff  <= posx_in;
         posy_ff  <= posy_in;
         ridx_ff  <= ridx_in;
         dgo_ff   <= dgo_in;
      end
      dist_ff  <= dist_in;
      dt_ff    <= dt_in;
      sturn_ff <= sturn_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      sc_ff    <= sc_in;
      ss_ff    <= ss_in;
      tan_ff   <= tan_in;
      m_ff     <= m_in;
      dth_ff   <= dth_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rt_ff    <= rt_in;
      zero_ff  <= zero_in;
   end

   assign rsp_bus.valid     = (state_ff == S_OUT);
   assign rsp_bus.pos_x     = posx_ff;
   assign rsp_bus.pos_y     = posy_ff;
   assign rsp_bus.heading   = head_ff;
   assign rsp_bus.rate_x    = rx_ff;
   assign rsp_bus.rate_y    = ry_ff;
   assign rsp_bus.turn_rate = rt_ff;
   assign rsp_bus.zero_step = zero_ff;

`ifndef NO_ASSERTIONS
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("sample taken while a pose beat is pending");
   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> (state_ff == S_CH || state_ff == S_CS))
      else $error("CORDIC finished outside a rotation state");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_TDIV || state_ff == S_RDIV))
      else $error("divider finished outside a division state");
   a_first_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && first_ff) |=> (state_ff == S_IDLE && !first_ff))
      else $error("first sample did not just store its timestamp");
`endif

endmodule
